// ===== hdl/tdpt_pkg.sv =====
// Shared constants, types and microcode table for the trial division prime tester.
package tdpt_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int TOTAL_BITS  = 32;
  localparam int IN_TDATA_W  = ((VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((TOTAL_BITS + 1 + 7) / 8) * 8;
  localparam int F_W         = VALUE_BITS / 2 + 1;
  localparam int ROOT_TOP    = ((VALUE_BITS - 2) / 2) * 2;
  localparam int ROOT_ITERS  = ROOT_TOP / 2 + 1;
  localparam int ITER_W      = $clog2(VALUE_BITS + 1);
  localparam int F_START     = 3;
  localparam int F_STEP      = 2;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t ST_IDLE      = 4'd0;
  localparam pc_t ST_CLASS     = 4'd1;
  localparam pc_t ST_ROOT_INIT = 4'd2;
  localparam pc_t ST_ROOT_STEP = 4'd3;
  localparam pc_t ST_TEST      = 4'd4;
  localparam pc_t ST_DIV_STEP  = 4'd5;
  localparam pc_t ST_CHECK     = 4'd6;
  localparam pc_t ST_ADVANCE   = 4'd7;
  localparam pc_t ST_PRIME     = 4'd8;
  localparam pc_t ST_EMIT      = 4'd9;
  localparam pc_t ST_BACK      = 4'd10;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLASSIFY,
    OP_ROOT_INIT,
    OP_ROOT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_ADVANCE,
    OP_SET_PRIME,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NEVER,
    COND_NO_INPUT,
    COND_TRIVIAL,
    COND_ITER_MORE,
    COND_F_GT_LIM,
    COND_REM_ZERO,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  typedef struct packed {
    logic no_input;
    logic trivial;
    logic iter_more;
    logic f_gt_lim;
    logic rem_zero;
    logic out_busy;
  } dp_status_t;

  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    case (pc)
      ST_IDLE:      w = '{op: OP_LOAD,      cond: COND_NO_INPUT,  target: ST_IDLE};
      ST_CLASS:     w = '{op: OP_CLASSIFY,  cond: COND_TRIVIAL,   target: ST_EMIT};
      ST_ROOT_INIT: w = '{op: OP_ROOT_INIT, cond: COND_NEVER,     target: ST_IDLE};
      ST_ROOT_STEP: w = '{op: OP_ROOT_STEP, cond: COND_ITER_MORE, target: ST_ROOT_STEP};
      ST_TEST:      w = '{op: OP_DIV_INIT,  cond: COND_F_GT_LIM,  target: ST_PRIME};
      ST_DIV_STEP:  w = '{op: OP_DIV_STEP,  cond: COND_ITER_MORE, target: ST_DIV_STEP};
      ST_CHECK:     w = '{op: OP_NONE,      cond: COND_REM_ZERO,  target: ST_EMIT};
      ST_ADVANCE:   w = '{op: OP_ADVANCE,   cond: COND_ALWAYS,    target: ST_TEST};
      ST_PRIME:     w = '{op: OP_SET_PRIME, cond: COND_NEVER,     target: ST_IDLE};
      ST_EMIT:      w = '{op: OP_EMIT,      cond: COND_OUT_BUSY,  target: ST_EMIT};
      ST_BACK:      w = '{op: OP_NONE,      cond: COND_ALWAYS,    target: ST_IDLE};
      default:      w = '{op: OP_NONE,      cond: COND_ALWAYS,    target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/trial_division_prime_test.sv =====
// Top level of the trial division prime tester: sequencer, datapath and stream ports.
//
//   channel   dir   word contents (lowest bit first)
//   s_axis    in    value[31:0]
//   m_axis    out   is_prime[0], trial_total[32:1], zero pad[39:33]
//
// Negative, zero, one, two and even values go from classification straight to the
// result word. Odd values take a bitwise square root, then try divisors in turn;
// the restoring remainder unit retires one dividend bit a cycle.
// One value is in work at a time; the next is taken once its result sits in the
// output register, which holds it until m_axis_tready. Synchronous reset clears
// the step counter, the running total and the output valid.
module trial_division_prime_test import tdpt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // value
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // is_prime, trial_total, pad
);

  uword_t                uw;
  dp_status_t            status;
  logic                  out_prime;
  logic [TOTAL_BITS-1:0] out_total;

  tdpt_useq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .uw     (uw)
  );

  tdpt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .uw        (uw),
    .in_valid  (s_axis_tvalid),
    .in_value  (s_axis_tdata[VALUE_BITS-1:0]),
    .out_ready (m_axis_tready),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_prime (out_prime),
    .out_total (out_total)
  );

  assign s_axis_tready = uw.op == OP_LOAD;
  assign m_axis_tdata  = {{(OUT_TDATA_W-TOTAL_BITS-1){1'b0}}, out_total, out_prime};

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken on consecutive cycles");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (uw.op == OP_EMIT && !status.out_busy) |=> m_axis_tvalid)
    else $error("result not loaded into output register");

  a_root_pass: assert property (@(posedge clk) disable iff (rst)
    (uw.op == OP_DIV_INIT && status.f_gt_lim) |=> uw.op == OP_SET_PRIME)
    else $error("divisor past root did not mark prime");

  a_word_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(uw.op) == OP_EMIT)
    else $error("result word raised outside emit step");
`endif

endmodule

// ===== hdl/tdpt_useq.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module tdpt_useq import tdpt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  dp_status_t status,
  output uword_t     uw
);

  pc_t  pc;
  pc_t  pc_next;
  logic taken;

  assign uw = ucode(pc);

  always_comb begin
    case (uw.cond)
      COND_ALWAYS:    taken = 1'b1;
      COND_NEVER:     taken = 1'b0;
      COND_NO_INPUT:  taken = status.no_input;
      COND_TRIVIAL:   taken = status.trivial;
      COND_ITER_MORE: taken = status.iter_more;
      COND_F_GT_LIM:  taken = status.f_gt_lim;
      COND_REM_ZERO:  taken = status.rem_zero;
      COND_OUT_BUSY:  taken = status.out_busy;
      default:        taken = 1'b0;
    endcase
    pc_next = taken ? uw.target : pc_t'(pc + 4'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== hdl/tdpt_datapath.sv =====
// Datapath: value, bitwise square root, restoring remainder, divisor, counters, output word.
module tdpt_datapath import tdpt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  uword_t                uw,
  input  logic                  in_valid,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic                  out_ready,
  output dp_status_t            status,
  output logic                  out_valid,
  output logic                  out_prime,
  output logic [TOTAL_BITS-1:0] out_total
);

  logic [VALUE_BITS-1:0] n;
  logic [VALUE_BITS-1:0] rx;
  logic [VALUE_BITS-1:0] rr;
  logic [VALUE_BITS-1:0] rbit;
  logic [VALUE_BITS-1:0] dn;
  logic [F_W-1:0]        f;
  logic [F_W-1:0]        rem;
  logic [ITER_W-1:0]     iter;
  logic [TOTAL_BITS-1:0] steps;
  logic [TOTAL_BITS-1:0] counter;
  logic                  prime;

  logic [VALUE_BITS:0]   root_sum;
  logic                  root_fit;
  logic [F_W:0]          div_t;
  logic                  div_fit;
  logic [F_W:0]          div_sub;
  logic [F_W-1:0]        rem_next;
  logic                  out_busy;
  logic                  emit;
  logic [TOTAL_BITS-1:0] total_next;

  always_comb begin
    root_sum   = {1'b0, rr} + {1'b0, rbit};
    root_fit   = {1'b0, rx} >= root_sum;
    div_t      = {rem, dn[VALUE_BITS-1]};
    div_fit    = div_t >= {1'b0, f};
    div_sub    = div_t - {1'b0, f};
    rem_next   = div_fit ? div_sub[F_W-1:0] : div_t[F_W-1:0];
    out_busy   = out_valid && !out_ready;
    emit       = (uw.op == OP_EMIT) && !out_busy;
    total_next = counter + steps;
  end

  always_comb begin
    status.no_input  = !in_valid;
    status.trivial   = n[VALUE_BITS-1] || !n[0] || (n == VALUE_BITS'(1));
    status.iter_more = iter != ITER_W'(1);
    status.f_gt_lim  = {{(VALUE_BITS-F_W){1'b0}}, f} > rr;
    status.rem_zero  = rem == '0;
    status.out_busy  = out_busy;
  end

  always_ff @(posedge clk) begin
    case (uw.op)
      OP_LOAD: begin
        if (in_valid) n <= in_value;
      end
      OP_CLASSIFY: begin
        prime <= n == VALUE_BITS'(2);
        steps <= '0;
      end
      OP_ROOT_INIT: begin
        rx    <= n;
        rr    <= '0;
        rbit  <= VALUE_BITS'(1) << ROOT_TOP;
        f     <= F_W'(F_START);
        steps <= TOTAL_BITS'(1);
        iter  <= ITER_W'(ROOT_ITERS);
      end
      OP_ROOT_STEP: begin
        if (root_fit) begin
          rx <= rx - root_sum[VALUE_BITS-1:0];
          rr <= (rr >> 1) + rbit;
        end else begin
          rr <= rr >> 1;
        end
        rbit <= rbit >> 2;
        iter <= iter - ITER_W'(1);
      end
      OP_DIV_INIT: begin
        rem  <= '0;
        dn   <= n;
        iter <= ITER_W'(VALUE_BITS);
      end
      OP_DIV_STEP: begin
        rem  <= rem_next;
        dn   <= dn << 1;
        iter <= iter - ITER_W'(1);
      end
      OP_ADVANCE: begin
        f     <= f + F_W'(F_STEP);
        steps <= steps + TOTAL_BITS'(1);
      end
      OP_SET_PRIME: begin
        prime <= 1'b1;
      end
      OP_EMIT: begin
        if (emit) begin
          out_prime <= prime;
          out_total <= total_next;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        counter   <= total_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
